@@ rtl/core/uat_pkg.sv @@
`default_nettype none

package uat_pkg;

   localparam int CAPACITY   = 128;
   localparam int DATA_W     = 64;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int GROUP      = 8;
   localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

   // request codes
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_SEARCH = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic write;
      logic compare;
      logic shift;
   } uat_ctl_type;

   // report the count modulo 256
   function automatic logic [7:0] to_count8(input logic [CNT_W-1:0] c);
      logic [CNT_W+7:0] t;
      t = {8'b0, c};
      return t[7:0];
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/uat_cell.sv @@
`default_nettype none

module uat_cell import uat_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire uat_ctl_type       ctl,
   input  wire logic [DATA_W-1:0] key,
   input  wire logic              sel,
   input  wire logic              valid,
   input  wire logic              hit,
   input  wire logic [DATA_W-1:0] next_entry,
   output logic [DATA_W-1:0]      entry,
   output logic                   match
);

   logic [DATA_W-1:0] entry_ff;
   logic              match_ff;

   // insert writes the slot at count, remove pulls from the right neighbor
   always_ff @(posedge clock) begin
      if (ctl.write && sel) begin
         entry_ff <= key;
      end else if (ctl.shift && hit) begin
         entry_ff <= next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (ctl.compare) begin
         match_ff <= valid && (entry_ff == key);
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

@@ rtl/core/uat_chain.sv @@
`default_nettype none

module uat_chain import uat_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire uat_ctl_type       ctl,
   input  wire logic [DATA_W-1:0] key,
   input  wire logic [CNT_W-1:0]  count,
   output logic                   found
);

   logic [DATA_W-1:0]     entry_q [CAPACITY];
   logic [CAPACITY-1:0]   match_vec;
   logic [NUM_GROUPS-1:0] group_any_ff;
   logic [NUM_GROUPS-1:0] group_any_in;
   logic [NUM_GROUPS-1:0] group_before;

   // per-group match summary, registered
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
      localparam int LO = g * GROUP;
      localparam int HI = ((g + 1) * GROUP > CAPACITY) ? CAPACITY - 1 : LO + GROUP - 1;
      assign group_any_in[g] = |match_vec[HI:LO];
      if (g == 0) begin : g_first
         assign group_before[g] = 1'b0;
      end else begin : g_rest
         assign group_before[g] = |group_any_ff[g-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_any_ff <= '0;
      end else begin
         group_any_ff <= group_any_in;
      end
   end

   assign found = |group_any_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int GI   = i / GROUP;
      localparam int BASE = GI * GROUP;
      logic              hit;
      logic              sel;
      logic              valid;
      logic [DATA_W-1:0] next_entry;

      // at or after the first match
      assign hit   = group_before[GI] | (|match_vec[i:BASE]);
      assign sel   = (count == CNT_W'(i));
      assign valid = (CNT_W'(i) < count);

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = entry_q[i];
      end else begin : g_mid
         assign next_entry = entry_q[i+1];
      end

      uat_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key),
         .sel        (sel),
         .valid      (valid),
         .hit        (hit),
         .next_entry (next_entry),
         .entry      (entry_q[i]),
         .match      (match_vec[i])
      );
   end

endmodule

`default_nettype wire

@@ rtl/core/unordered_array_table.sv @@
// channel   direction  handshake           payload
// req       in         req_valid/req_stall  req_type, req_value
// rsp       out        rsp_valid/rsp_stall  rsp_status, rsp_entry_count
//
// insert is answered straight from the compare state; search and remove pass through
// compare in every cell, registered group summary, then shift and respond
// one transaction is in flight at a time; req_stall is low only when idle
// the response sits in an output register, so a stalled rsp only holds the
// block when the next response is ready to be written
// synchronous active-high reset clears the count; the cell storage is not cleared
`default_nettype none

module unordered_array_table import uat_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_type,
   input  wire logic [DATA_W-1:0] req_value,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_entry_count
);

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_CMP   = 4'b0010,
      S_RED   = 4'b0100,
      S_APPLY = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        type_ff;
   logic [DATA_W-1:0] key_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_count_ff, rsp_count_in;

   uat_ctl_type       ctl;
   logic              found;
   logic              out_free;
   logic              accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);

   // the output register can take a new response this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ctl           = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            case (type_ff)
               REQ_INSERT: begin
                  if (out_free) begin
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        // the cell at index count captures the key
                        ctl.write     = 1'b1;
                        count_in      = count_ff + 1'b1;
                        rsp_status_in = ST_OK;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_count_in = to_count8(count_in);
                     state_in     = S_IDLE;
                  end
               end
               REQ_SEARCH, REQ_REMOVE: begin
                  // every valid cell compares against the key in parallel
                  ctl.compare = 1'b1;
                  state_in    = S_RED;
               end
               default: begin
                  // unused code: no change, reported as not found
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOT_FOUND;
                     rsp_count_in  = to_count8(count_ff);
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end
         S_RED: begin
            // group summaries settle in the chain
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) begin
               if (found) begin
                  rsp_status_in = ST_OK;
                  if (type_ff == REQ_REMOVE) begin
                     // cells from the first match upward take their neighbor's entry
                     ctl.shift = 1'b1;
                     count_in  = count_ff - 1'b1;
                  end
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
               rsp_valid_in = 1'b1;
               rsp_count_in = to_count8(count_in);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         key_ff  <= req_value;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   uat_chain u_chain (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .key   (key_ff),
      .count (count_ff),
      .found (found)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

@@ rtl/core/uat_checker.sv @@
`default_nettype none

module uat_checker import uat_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_status,
   input wire logic [7:0] rsp_entry_count
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("stalled response changed");

   // status is never the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_NOT_FOUND)
                    || (rsp_status == ST_FULL))
      else $error("bad status code");

   // one transaction at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted back to back");

   // a refused insert reports a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == to_count8(CNT_W'(CAPACITY)))
      else $error("full status with wrong count");

endmodule

bind unordered_array_table uat_checker u_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import uat_pkg::*;

   // request code the block has no operation for, it must be ignored
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int NUM_DIR     = 22;
   localparam int HOLD_CYCLES = 300;   // long rsp hold-off so the block backs up
   localparam int DRAIN_LIMIT = 2000;  // cycles allowed for the last responses
   localparam int TAIL_CYCLES = 20;    // quiet cycles to catch stray responses

   // value patterns for the directed part
   localparam logic [DATA_W-1:0] ALL_ONES  = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] SIGN_ONLY = {1'b1, {DATA_W-1{1'b0}}};
   localparam logic [DATA_W-1:0] NEAR_MAX  = {1'b0, {DATA_W-1{1'b1}}};
   localparam logic [DATA_W-1:0] PAT_A     = 64'h0123456789abcdef;
   localparam logic [DATA_W-1:0] PAT_B     = 64'hfedcba9876543210;

   // one directed row: the request, and a typed-in response where it is obvious
   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] key;
      logic              typed;
      logic [1:0]        status;
      logic [7:0]        count;
   } dir_row_type;

   // what one rsp transaction should carry
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] count;
   } rsp_expect_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_type;
   logic [DATA_W-1:0] req_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   logic [7:0]        rsp_entry_count;

   // shadow copy of the table contents, index 0 is the oldest live entry
   logic [DATA_W-1:0] shadow_vals[$];
   // responses still owed by the block, oldest first
   rsp_expect_type    pending_rsp[$];
   rsp_expect_type    got_exp;

   dir_row_type dir_rows [NUM_DIR];

   int  errors       = 0;
   int  requests     = 0;
   int  responses    = 0;
   int  counted      = 0;   // random requests that do real work
   int  peak_fill    = 0;
   int  n_ok         = 0;
   int  n_missed     = 0;
   int  n_full       = 0;
   int  target;
   int  wait_cycles;
   bit  quiet_phase  = 1'b0;  // no idling on either side
   bit  hold_request = 1'b0;  // asks the rsp side for one long hold-off

   unordered_array_table i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // overall watchdog
   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

   // predictor: apply one accepted request to the shadow table
   // search and remove both look for the lowest-indexed match
   function automatic void table_update(input logic [1:0] kind,
                                        input logic [DATA_W-1:0] key,
                                        output logic [1:0] st,
                                        output logic [7:0] cnt);
      int i;
      i = 0;
      while (i < shadow_vals.size() && shadow_vals[i] != key)
         i++;
      st = ST_NOT_FOUND;
      case (kind)
         REQ_INSERT: begin
            // a full table refuses the insert and stays as it is
            if (shadow_vals.size() >= CAPACITY) begin
               st = ST_FULL;
            end else begin
               shadow_vals.push_back(key);
               st = ST_OK;
            end
         end
         REQ_SEARCH: begin
            if (i < shadow_vals.size())
               st = ST_OK;
         end
         REQ_REMOVE: begin
            // later entries close the gap, order is kept
            if (i < shadow_vals.size()) begin
               shadow_vals.delete(i);
               st = ST_OK;
            end
         end
         default: st = ST_NOT_FOUND;
      endcase
      cnt = 8'(shadow_vals.size());
      if (shadow_vals.size() > peak_fill)
         peak_fill = shadow_vals.size();
   endfunction

   // key for a random request: mostly live entries so search and remove hit,
   // the top entry often so removal of the last slot is exercised,
   // small values so duplicates pile up, single-bit and single-zero patterns, and random values
   function automatic logic [DATA_W-1:0] pick_key();
      int n;
      int r;
      n = shadow_vals.size();
      r = $urandom_range(0, 99);
      if (n > 0 && r < 15)
         return shadow_vals[n-1];
      if (n > 0 && r < 65)
         return shadow_vals[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 3))
         0:       return 64'($urandom_range(0, 7));
         1:       return 64'h1 << $urandom_range(0, 63);
         2:       return ~(64'h1 << $urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // offer one req transaction and hold it until accepted
   task automatic offer(input logic [1:0] kind, input logic [DATA_W-1:0] key,
                        input logic typed, input logic [1:0] t_status,
                        input logic [7:0] t_count);
      logic [1:0] st;
      logic [7:0] cnt;
      @(negedge clock);
      req_valid <= 1'b1;
      req_type  <= kind;
      req_value <= key;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      table_update(kind, key, st, cnt);
      if (typed)
         pending_rsp.push_back({t_status, t_count});
      else
         pending_rsp.push_back({st, cnt});
      requests++;
   endtask

   // sometimes drop valid for a burst, with junk on the payload meanwhile
   task automatic sender_gap();
      int n;
      if (quiet_phase || $urandom_range(0, 3) != 0)
         return;
      n = $urandom_range(1, 16);
      @(negedge clock);
      req_valid <= 1'b0;
      req_type  <= 2'($urandom);
      req_value <= {$urandom, $urandom};
      repeat (n - 1) @(negedge clock);
   endtask

   // one random request; remove takes whatever share is left
   task automatic random_item(input int ins_pct, input int srch_pct);
      int r;
      logic [1:0] kind;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 31) == 0)
         kind = REQ_UNUSED;
      else if (r < ins_pct)
         kind = REQ_INSERT;
      else if (r < ins_pct + srch_pct)
         kind = REQ_SEARCH;
      else
         kind = REQ_REMOVE;
      offer(kind, pick_key(), 1'b0, ST_OK, 8'd0);
      if (kind != REQ_UNUSED)
         counted++;
      sender_gap();
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      errors++;
      if (errors <= 10)
         $display("tb: mismatch on %s at response %0d: expected %0d, got %0d",
                  what, responses, want, got);
   endtask

   // rsp side: random stall bursts, one long hold-off on request,
   // nothing at all in the quiet phase
   initial begin : rsp_pacing
      int burst_left;
      int hold_left;
      bit burst_stall;
      burst_left  = 0;
      hold_left   = 0;
      burst_stall = 1'b0;
      rsp_stall   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_stall   <= 1'b1;
         end else begin
            if (burst_left == 0) begin
               burst_stall = ($urandom_range(0, 2) == 0);
               burst_left  = $urandom_range(1, 16);
            end
            burst_left--;
            rsp_stall <= burst_stall && !quiet_phase;
         end
      end
   end

   // check every accepted rsp transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response count", 8'd0, rsp_entry_count);
         end else begin
            got_exp = pending_rsp.pop_front();
            if (rsp_status !== got_exp.status)
               report_mismatch("status", {6'd0, got_exp.status}, {6'd0, rsp_status});
            if (rsp_entry_count !== got_exp.count)
               report_mismatch("entry count", got_exp.count, rsp_entry_count);
            case (got_exp.status)
               ST_OK:   n_ok++;
               ST_FULL: n_full++;
               default: n_missed++;
            endcase
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_type  = REQ_INSERT;
      req_value = '0;

      // directed rows: empty table, ignored code, duplicates, sign pattern,
      // removal of first, middle and last entries
      dir_rows[0]  = {REQ_SEARCH, 64'h0,     1'b1, ST_NOT_FOUND, 8'd0};
      dir_rows[1]  = {REQ_REMOVE, 64'h0,     1'b1, ST_NOT_FOUND, 8'd0};
      dir_rows[2]  = {REQ_UNUSED, ALL_ONES,  1'b1, ST_NOT_FOUND, 8'd0};
      dir_rows[3]  = {REQ_INSERT, 64'h0,     1'b1, ST_OK,        8'd1};
      dir_rows[4]  = {REQ_INSERT, ALL_ONES,  1'b1, ST_OK,        8'd2};
      dir_rows[5]  = {REQ_INSERT, ALL_ONES,  1'b1, ST_OK,        8'd3};
      dir_rows[6]  = {REQ_INSERT, SIGN_ONLY, 1'b1, ST_OK,        8'd4};
      dir_rows[7]  = {REQ_SEARCH, ALL_ONES,  1'b1, ST_OK,        8'd4};
      dir_rows[8]  = {REQ_SEARCH, NEAR_MAX,  1'b1, ST_NOT_FOUND, 8'd4};
      dir_rows[9]  = {REQ_REMOVE, ALL_ONES,  1'b1, ST_OK,        8'd3};
      dir_rows[10] = {REQ_SEARCH, ALL_ONES,  1'b1, ST_OK,        8'd3};
      dir_rows[11] = {REQ_UNUSED, 64'h0,     1'b1, ST_NOT_FOUND, 8'd3};
      dir_rows[12] = {REQ_REMOVE, SIGN_ONLY, 1'b1, ST_OK,        8'd2};
      dir_rows[13] = {REQ_SEARCH, SIGN_ONLY, 1'b1, ST_NOT_FOUND, 8'd2};
      dir_rows[14] = {REQ_REMOVE, 64'h0,     1'b1, ST_OK,        8'd1};
      dir_rows[15] = {REQ_SEARCH, ALL_ONES,  1'b1, ST_OK,        8'd1};
      dir_rows[16] = {REQ_INSERT, PAT_A,     1'b0, ST_OK,        8'd0};
      dir_rows[17] = {REQ_INSERT, PAT_B,     1'b0, ST_OK,        8'd0};
      dir_rows[18] = {REQ_SEARCH, PAT_A,     1'b0, ST_OK,        8'd0};
      dir_rows[19] = {REQ_REMOVE, PAT_B,     1'b0, ST_OK,        8'd0};
      dir_rows[20] = {REQ_REMOVE, ALL_ONES,  1'b0, ST_OK,        8'd0};
      dir_rows[21] = {REQ_REMOVE, PAT_A,     1'b0, ST_OK,        8'd0};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[n]) begin
         offer(dir_rows[n].kind, dir_rows[n].key, dir_rows[n].typed,
               dir_rows[n].status, dir_rows[n].count);
         sender_gap();
      end

      // mixed traffic at low occupancy
      while (counted < 100)
         random_item(45, 25);

      // fill to capacity; the rsp side holds off for a long stretch while
      // the sender keeps offering, so the block has to stall req
      hold_request = 1'b1;
      while (shadow_vals.size() < CAPACITY)
         random_item(85, 10);
      // at capacity: refused inserts, searches, removal of the top slot
      repeat (12)
         random_item(70, 15);

      // drain down to empty, then poke the empty table
      while (shadow_vals.size() > 0)
         random_item(10, 15);
      repeat (5)
         random_item(10, 15);

      // back to back on both sides until the end
      quiet_phase = 1'b1;
      target = counted + 180;
      while (counted < target)
         random_item(40, 30);

      @(negedge clock);
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_rsp.size() != 0) begin
         errors += pending_rsp.size();
         $display("tb: %0d expected responses never arrived", pending_rsp.size());
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d requests and %0d responses; %0d ok, %0d not found, %0d full",
               requests, responses, n_ok, n_missed, n_full);
      $display("tb: peak occupancy %0d of %0d entries, %0d mismatches",
               peak_fill, CAPACITY, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
